// ===== hw/rtl/ntt_pkg.sv =====
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types and constants of the note tempo tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

  localparam int unsigned TEMPO_W = 18;
  localparam int unsigned CAND_W  = 29;
  localparam int unsigned DVD_W   = 27;
  localparam int unsigned PROD_W  = CAND_W + TEMPO_W;
  localparam int unsigned BPROD_W = 35;
  localparam int unsigned QB_SHIFT = 17;
  localparam int unsigned QBP_W    = 37;
  localparam int unsigned QB_RECIP_SHIFT = 25;

  localparam logic [TEMPO_W-1:0] ONE_Q16    = 18'd65536;
  localparam logic [DVD_W-1:0]   RAW_NUM    = 27'd131072000;
  localparam logic [BPROD_W-1:0] QB_HALF    = 35'd8192000;
  // ceil(2^25 / 125): exact floor(y / 125) for any 18-bit y
  localparam logic [18:0]        QB_RECIP   = 19'd268436;
  localparam logic [31:0]        BEAT_STEP  = 32'd4;
  localparam logic [2:0]         NUM_CAND   = 3'd5;

  localparam logic [15:0]        RST_THR    = 16'd50;
  localparam logic [TEMPO_W-1:0] RST_FLOOR  = 18'd65536;
  localparam logic [TEMPO_W-1:0] RST_CEIL   = 18'd174763;
  localparam logic [TEMPO_W-1:0] RST_FUP    = 18'd76459;
  localparam logic [TEMPO_W-1:0] RST_FDN    = 18'd152917;
  localparam logic [15:0]        RST_SLEW   = 16'd1311;
  localparam logic [TEMPO_W-1:0] RST_INIT   = 18'd109227;

  localparam logic [2:0] REG_GAP_THR    = 3'd0;
  localparam logic [2:0] REG_FLOOR      = 3'd1;
  localparam logic [2:0] REG_CEILING    = 3'd2;
  localparam logic [2:0] REG_FOLD_UP    = 3'd3;
  localparam logic [2:0] REG_FOLD_DOWN  = 3'd4;
  localparam logic [2:0] REG_SLEW       = 3'd5;
  localparam logic [2:0] REG_INIT_TEMPO = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_SORT,
    ST_SHIFT,
    ST_MED,
    ST_DIVT,
    ST_DIVT_WAIT,
    ST_CAND_INIT,
    ST_CAND,
    ST_FOLD_UP,
    ST_FOLD_DN,
    ST_CLAMP,
    ST_SLEW,
    ST_BEAT_MUL,
    ST_DIVB,
    ST_BEAT_ADD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic load;
    logic sort_step;
    logic shift_step;
    logic med;
    logic div_start;
    logic div_beat;
    logic cand_init;
    logic cand_step;
    logic fold_up;
    logic fold_dn;
    logic clamp;
    logic slew;
    logic beat_mul;
    logic beat_add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic chg;
    logic est_need;
    logic sort_last;
    logic shift_done;
    logic m2_zero;
    logic div_done;
    logic cand_done;
    logic fold_up_go;
    logic fold_dn_go;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ntt_div.sv =====
// ----------------------------------------------------------------------------
// ntt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_div #(
  parameter int unsigned DVD_W = 27,
  parameter int unsigned DVS_W = 21
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    quo_d = {quo_q[DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ntt_dp.sv =====
// ----------------------------------------------------------------------------
// ntt_dp
// Datapath: registers, gap ring, median sorter, tempo fold/clamp/slew, beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_dp #(
  parameter int unsigned GAP_WINDOW = 12,
  parameter int unsigned GAP_WIDTH  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [17:0] cfg_data_i,
  input  wire logic [6:0]  note_value_i,
  input  wire logic [15:0] interval_ms_i,
  input  wire ntt_pkg::cmd_t cmd_i,
  output ntt_pkg::sts_t    sts_o,
  output logic [17:0]      tempo_bps_o,
  output logic             has_estimate_o,
  output logic [31:0]      beat_quarters_o,
  output logic [6:0]       pitch_out_o
);

  localparam int unsigned CNT_W = $clog2(GAP_WINDOW + 1);
  localparam int unsigned M2_W  = GAP_WIDTH + 1;
  localparam int unsigned TW    = ntt_pkg::TEMPO_W;
  localparam int unsigned CW    = ntt_pkg::CAND_W;
  localparam int unsigned QW    = ntt_pkg::QBP_W - ntt_pkg::QB_RECIP_SHIFT;

  logic [15:0]    thr_q, slew_q;
  logic [TW-1:0]  floor_q, ceil_q, fup_q, fdn_q, last_tempo_q;
  logic [6:0]     pitch_q, lpitch_q;
  logic [15:0]    ivl_q;
  logic [1:0]     es_q;
  logic [GAP_WIDTH-1:0] rg_q;
  logic [GAP_WIDTH-1:0] ring_q [GAP_WINDOW];
  logic [GAP_WIDTH-1:0] sort_q [GAP_WINDOW];
  logic [GAP_WIDTH-1:0] sort_d [GAP_WINDOW];
  logic [CNT_W-1:0] gcnt_q, scnt_q, shcnt_q;
  logic [M2_W-1:0]  m2_q;
  logic [CW-1:0]    best_q;
  logic [2:0]       ci_q;
  logic             ph_q;
  logic [ntt_pkg::PROD_W-1:0] prod_a_q, prod_b;
  logic [TW-1:0]    dstep_q;
  logic [ntt_pkg::BPROD_W-1:0] bprod_q;
  logic [QW-1:0]    qb_q;
  logic [31:0]      beat_q;
  logic [TW-1:0]    out_tempo_q;
  logic             out_est_q;
  logic [31:0]      out_beat_q;
  logic [6:0]       out_pitch_q;

  logic [GAP_WIDTH:0]   rg_sum;
  logic [GAP_WIDTH-1:0] rg_sat;
  logic                 push, chg;
  logic [GAP_WIDTH-1:0] sort1;
  logic [CNT_W-1:0]     sh_target;
  logic [ntt_pkg::DVD_W-1:0] raw;
  logic                 div_done;
  logic [CW-1:0]        cand, p_w, bmax, cmax, t1, t2, t3, t4;
  logic [TW-1:0]        bmin, cmin, tempo_cur;
  logic [TW:0]          hi;
  logic [TW-1:0]        lo;
  logic [33:0]          slew_prod;
  logic [ntt_pkg::QBP_W-1:0] qb_prod;

  always_comb begin
    rg_sum = {1'b0, rg_q} + (GAP_WIDTH+1)'(ivl_q);
    rg_sat = rg_sum[GAP_WIDTH] ? '1 : rg_sum[GAP_WIDTH-1:0];
    push   = rg_sat > GAP_WIDTH'(thr_q);
    chg    = (es_q != 2'd0) && (pitch_q != lpitch_q);
  end

  always_comb begin
    for (int i = 0; i < GAP_WINDOW; i++) sort_d[i] = sort_q[i];
    for (int i = 0; i + 1 < GAP_WINDOW; i++) begin
      if ((1'(i) == scnt_q[0]) && (sort_q[i] > sort_q[i+1])) begin
        sort_d[i]   = sort_q[i+1];
        sort_d[i+1] = sort_q[i];
      end
    end
  end

  if (GAP_WINDOW > 1) begin : g_s1
    assign sort1 = sort_q[1];
  end else begin : g_s1z
    assign sort1 = '0;
  end

  assign sh_target = (gcnt_q - 1'b1) >> 1;
  assign tempo_cur = (gcnt_q != '0) ? last_tempo_q : ntt_pkg::ONE_Q16;

  always_comb begin
    unique case (ci_q)
      3'd0:    cand = CW'(raw >> 2);
      3'd1:    cand = CW'(raw >> 1);
      3'd2:    cand = CW'(raw);
      3'd3:    cand = CW'({raw, 1'b0});
      default: cand = CW'({raw, 2'b00});
    endcase
    p_w    = CW'(last_tempo_q);
    cmax   = (cand > p_w) ? cand : p_w;
    cmin   = (cand > p_w) ? last_tempo_q : cand[TW-1:0];
    bmax   = (best_q > p_w) ? best_q : p_w;
    bmin   = (best_q > p_w) ? last_tempo_q : best_q[TW-1:0];
    prod_b = ntt_pkg::PROD_W'(bmax) * ntt_pkg::PROD_W'(cmin);
    t1 = (best_q < CW'(floor_q)) ? CW'(floor_q) : best_q;
    t2 = (t1 > CW'(ceil_q)) ? CW'(ceil_q) : t1;
    slew_prod = 34'(last_tempo_q) * 34'(slew_q);
    hi = {1'b0, last_tempo_q} + (TW+1)'(dstep_q);
    lo = last_tempo_q - dstep_q;
    t3 = (best_q > CW'(hi)) ? CW'(hi) : best_q;
    t4 = (t3 < CW'(lo)) ? CW'(lo) : t3;
  end

  // quarter beats: drop the 2^17 factor, then divide by 125 by reciprocal
  assign qb_prod = ntt_pkg::QBP_W'(bprod_q[ntt_pkg::BPROD_W-1:ntt_pkg::QB_SHIFT])
                 * ntt_pkg::QBP_W'(ntt_pkg::QB_RECIP);

  ntt_div #(
    .DVD_W(ntt_pkg::DVD_W),
    .DVS_W(M2_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(ntt_pkg::RAW_NUM),
    .divisor_i (m2_q),
    .done_o    (div_done),
    .quotient_o(raw)
  );

  always_comb begin
    sts_o.chg        = chg;
    sts_o.est_need   = chg && ((gcnt_q != '0) || push);
    sts_o.sort_last  = scnt_q == CNT_W'(GAP_WINDOW - 1);
    sts_o.shift_done = shcnt_q == sh_target;
    sts_o.m2_zero    = m2_q == '0;
    sts_o.div_done   = div_done;
    sts_o.cand_done  = ci_q == ntt_pkg::NUM_CAND;
    sts_o.fold_up_go = (best_q != '0) && (best_q < CW'(fup_q)) &&
                       ({best_q, 1'b0} <= (CW+1)'(ceil_q));
    sts_o.fold_dn_go = (best_q > CW'(fdn_q)) && ((best_q >> 1) >= CW'(floor_q));
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= ntt_pkg::RST_THR;
      floor_q      <= ntt_pkg::RST_FLOOR;
      ceil_q       <= ntt_pkg::RST_CEIL;
      fup_q        <= ntt_pkg::RST_FUP;
      fdn_q        <= ntt_pkg::RST_FDN;
      slew_q       <= ntt_pkg::RST_SLEW;
      last_tempo_q <= ntt_pkg::RST_INIT;
      es_q         <= '0;
      lpitch_q     <= '0;
      rg_q         <= '0;
      gcnt_q       <= '0;
      beat_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ntt_pkg::REG_GAP_THR:    thr_q        <= cfg_data_i[15:0];
          ntt_pkg::REG_FLOOR:      floor_q      <= cfg_data_i;
          ntt_pkg::REG_CEILING:    ceil_q       <= cfg_data_i;
          ntt_pkg::REG_FOLD_UP:    fup_q        <= cfg_data_i;
          ntt_pkg::REG_FOLD_DOWN:  fdn_q        <= cfg_data_i;
          ntt_pkg::REG_SLEW:       slew_q       <= cfg_data_i[15:0];
          ntt_pkg::REG_INIT_TEMPO: last_tempo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (es_q != 2'd2) es_q <= es_q + 1'b1;
        if (es_q == 2'd0) begin
          rg_q     <= '0;
          lpitch_q <= pitch_q;
        end else if (!chg) begin
          rg_q   <= rg_sat;
          beat_q <= beat_q + ntt_pkg::BEAT_STEP;
        end else begin
          rg_q     <= '0;
          lpitch_q <= pitch_q;
          if (push && (gcnt_q != CNT_W'(GAP_WINDOW))) gcnt_q <= gcnt_q + 1'b1;
        end
      end
      if (cmd_i.slew) last_tempo_q <= t4[TW-1:0];
      if (cmd_i.beat_add) beat_q <= beat_q + 32'(qb_q);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pitch_q <= note_value_i;
      ivl_q   <= interval_ms_i;
    end
    if (cmd_i.update && chg && push) begin
      ring_q[0] <= rg_sat;
      for (int i = 1; i < GAP_WINDOW; i++) ring_q[i] <= ring_q[i-1];
    end
    if (cmd_i.load) begin
      for (int i = 0; i < GAP_WINDOW; i++) begin
        sort_q[i] <= (CNT_W'(i) < gcnt_q) ? ring_q[i] : '1;
      end
      scnt_q  <= '0;
      shcnt_q <= '0;
    end else if (cmd_i.sort_step) begin
      for (int i = 0; i < GAP_WINDOW; i++) sort_q[i] <= sort_d[i];
      scnt_q <= scnt_q + 1'b1;
    end else if (cmd_i.shift_step) begin
      for (int i = 0; i + 1 < GAP_WINDOW; i++) sort_q[i] <= sort_q[i+1];
      shcnt_q <= shcnt_q + 1'b1;
    end
    if (cmd_i.med) begin
      m2_q <= gcnt_q[0] ? {sort_q[0], 1'b0} : M2_W'(sort_q[0]) + M2_W'(sort1);
    end
    if (cmd_i.cand_init) begin
      best_q <= CW'(raw >> 2);
      ci_q   <= '0;
      ph_q   <= 1'b0;
    end else if (cmd_i.cand_step) begin
      if (!ph_q) begin
        if (cand == '0) ci_q <= ci_q + 1'b1;
        else begin
          prod_a_q <= ntt_pkg::PROD_W'(cmax) * ntt_pkg::PROD_W'(bmin);
          ph_q     <= 1'b1;
        end
      end else begin
        if (prod_a_q < prod_b) best_q <= cand;
        ci_q <= ci_q + 1'b1;
        ph_q <= 1'b0;
      end
    end else if (cmd_i.fold_up) begin
      best_q <= {best_q[CW-2:0], 1'b0};
    end else if (cmd_i.fold_dn) begin
      best_q <= best_q >> 1;
    end else if (cmd_i.clamp) begin
      best_q  <= t2;
      dstep_q <= slew_prod[33:16];
    end
    if (cmd_i.beat_mul) begin
      bprod_q <= ntt_pkg::BPROD_W'(34'(ivl_q) * 34'(tempo_cur)) + ntt_pkg::QB_HALF;
    end
    if (cmd_i.div_beat) begin
      qb_q <= qb_prod[ntt_pkg::QBP_W-1:ntt_pkg::QB_RECIP_SHIFT];
    end
    if (cmd_i.emit) begin
      out_tempo_q <= tempo_cur;
      out_est_q   <= gcnt_q != '0;
      out_beat_q  <= beat_q;
      out_pitch_q <= pitch_q;
    end
  end

  assign tempo_bps_o     = out_tempo_q;
  assign has_estimate_o  = out_est_q;
  assign beat_quarters_o = out_beat_q;
  assign pitch_out_o     = out_pitch_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ntt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntt_ctrl
// Sequencer for one note event through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire ntt_pkg::sts_t sts_i,
  output ntt_pkg::cmd_t      cmd_o
);

  ntt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            in_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntt_pkg::ST_IDLE:      if (in_acc) state_d = ntt_pkg::ST_UPDATE;
      ntt_pkg::ST_UPDATE: begin
        if (sts_i.est_need) state_d = ntt_pkg::ST_LOAD;
        else if (sts_i.chg) state_d = ntt_pkg::ST_BEAT_MUL;
        else                state_d = ntt_pkg::ST_EMIT;
      end
      ntt_pkg::ST_LOAD:      state_d = ntt_pkg::ST_SORT;
      ntt_pkg::ST_SORT:      if (sts_i.sort_last) state_d = ntt_pkg::ST_SHIFT;
      ntt_pkg::ST_SHIFT:     if (sts_i.shift_done) state_d = ntt_pkg::ST_MED;
      ntt_pkg::ST_MED:       state_d = ntt_pkg::ST_DIVT;
      ntt_pkg::ST_DIVT: begin
        state_d = sts_i.m2_zero ? ntt_pkg::ST_BEAT_MUL : ntt_pkg::ST_DIVT_WAIT;
      end
      ntt_pkg::ST_DIVT_WAIT: if (sts_i.div_done) state_d = ntt_pkg::ST_CAND_INIT;
      ntt_pkg::ST_CAND_INIT: state_d = ntt_pkg::ST_CAND;
      ntt_pkg::ST_CAND:      if (sts_i.cand_done) state_d = ntt_pkg::ST_FOLD_UP;
      ntt_pkg::ST_FOLD_UP:   if (!sts_i.fold_up_go) state_d = ntt_pkg::ST_FOLD_DN;
      ntt_pkg::ST_FOLD_DN:   if (!sts_i.fold_dn_go) state_d = ntt_pkg::ST_CLAMP;
      ntt_pkg::ST_CLAMP:     state_d = ntt_pkg::ST_SLEW;
      ntt_pkg::ST_SLEW:      state_d = ntt_pkg::ST_BEAT_MUL;
      ntt_pkg::ST_BEAT_MUL:  state_d = ntt_pkg::ST_DIVB;
      ntt_pkg::ST_DIVB:      state_d = ntt_pkg::ST_BEAT_ADD;
      ntt_pkg::ST_BEAT_ADD:  state_d = ntt_pkg::ST_EMIT;
      ntt_pkg::ST_EMIT:      if (out_free) state_d = ntt_pkg::ST_IDLE;
      default:               state_d = ntt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = state_q != ntt_pkg::ST_IDLE;
    unique case (state_q)
      ntt_pkg::ST_IDLE:      cmd_o.capture    = in_acc;
      ntt_pkg::ST_UPDATE:    cmd_o.update     = 1'b1;
      ntt_pkg::ST_LOAD:      cmd_o.load       = 1'b1;
      ntt_pkg::ST_SORT:      cmd_o.sort_step  = 1'b1;
      ntt_pkg::ST_SHIFT:     cmd_o.shift_step = !sts_i.shift_done;
      ntt_pkg::ST_MED:       cmd_o.med        = 1'b1;
      ntt_pkg::ST_DIVT:      cmd_o.div_start  = !sts_i.m2_zero;
      ntt_pkg::ST_CAND_INIT: cmd_o.cand_init  = 1'b1;
      ntt_pkg::ST_CAND:      cmd_o.cand_step  = !sts_i.cand_done;
      ntt_pkg::ST_FOLD_UP:   cmd_o.fold_up    = sts_i.fold_up_go;
      ntt_pkg::ST_FOLD_DN:   cmd_o.fold_dn    = sts_i.fold_dn_go;
      ntt_pkg::ST_CLAMP:     cmd_o.clamp      = 1'b1;
      ntt_pkg::ST_SLEW:      cmd_o.slew       = 1'b1;
      ntt_pkg::ST_BEAT_MUL:  cmd_o.beat_mul   = 1'b1;
      ntt_pkg::ST_DIVB:      cmd_o.div_beat   = 1'b1;
      ntt_pkg::ST_BEAT_ADD:  cmd_o.beat_add   = 1'b1;
      ntt_pkg::ST_EMIT:      cmd_o.emit       = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a pending one");

  a_acc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ntt_pkg::ST_UPDATE))
    else $error("accepted request not processed");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ntt_pkg::ST_EMIT))
    else $error("result valid without emit");

endmodule

`default_nettype wire

// ===== hw/rtl/note_tempo_tracker.sv =====
// ----------------------------------------------------------------------------
// note_tempo_tracker
// Tempo and quarter-beat position tracker driven by note events.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one request per note event:
// pitch and milliseconds since the previous event. Each request yields one
// result on the output channel (out_valid_o / out_stall_i): tempo in Q2.16
// beats per second, an estimate flag, the beat position and the pitch.
// A first or repeated pitch goes from the update straight to the result, a
// pitch change without gaps adds the beat computation, and re-estimation
// adds GAP_WINDOW sort passes, up to GAP_WINDOW/2 shifts, a divide,
// candidate compares and fold loops. One event is processed at a time;
// in_stall_o is high until the result is registered, and the next request
// can be taken in the following cycle. A result waits in the output
// register while out_stall_i is high; the sequencer holds the next result
// until that register is free. The user must make configuration writes
// (cfg_valid_i, cfg_ready_o always high) only while idle; the block does
// not enforce it. Reset loads register defaults, clears the tracker state.
// ----------------------------------------------------------------------------
`default_nettype none

module note_tempo_tracker #(
  parameter int unsigned GAP_WINDOW = 12,
  parameter int unsigned GAP_WIDTH  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [17:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [6:0]  note_value_i,
  input  wire logic [15:0] interval_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [17:0]      tempo_bps_o,
  output logic             has_estimate_o,
  output logic [31:0]      beat_quarters_o,
  output logic [6:0]       pitch_out_o
);

  ntt_pkg::cmd_t cmd;
  ntt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ntt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntt_dp #(
    .GAP_WINDOW(GAP_WINDOW),
    .GAP_WIDTH (GAP_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .note_value_i   (note_value_i),
    .interval_ms_i  (interval_ms_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .tempo_bps_o    (tempo_bps_o),
    .has_estimate_o (has_estimate_o),
    .beat_quarters_o(beat_quarters_o),
    .pitch_out_o    (pitch_out_o)
  );

endmodule

`default_nettype wire
